// ===== hdl/nsf_pkg.sv =====
// Shared types, codes and helpers for the NMEA sentence framer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package nsf_pkg;

   localparam int ID_SLOTS_DEFAULT = 6;
   localparam int ID_SLOTS_MAX     = 6;
   localparam int CSR_WIDTH        = 32;
   localparam int ID_WIDTH         = 32;

   localparam logic [7:0] MAX_LENGTH_RESET = 8'd128;

   localparam logic       OP_BYTE    = 1'b0;
   localparam logic       OP_RELEASE = 1'b1;

   localparam int CSR_MAX_LENGTH  = 0;
   localparam int CSR_ID_COUNT    = 1;
   localparam int CSR_ACCEPT_ID_0 = 2;

   localparam logic [2:0] ST_BYPASS      = 3'd0;
   localparam logic [2:0] ST_STARTED     = 3'd1;
   localparam logic [2:0] ST_IN_PROGRESS = 3'd2;
   localparam logic [2:0] ST_READY       = 3'd3;
   localparam logic [2:0] ST_TOO_BIG     = 3'd4;
   localparam logic [2:0] ST_SKIPPING    = 3'd5;
   localparam logic [2:0] ST_CSUM_ERROR  = 3'd6;

   localparam logic [7:0] CH_START = 8'h24;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PROP  = 8'h50;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  byte_index;
      logic [7:0]  byte_out;
      logic        store_enable;
      logic [15:0] talker_code;
      logic [31:0] sentence_code;
      logic        proprietary;
   } rsp_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
      return v;
   endfunction

endpackage

// ===== hdl/nsf_core.sv =====
// Sentence state and per-item framing logic of the NMEA sentence framer.
// Depends on nsf_pkg; result is combinational, registered by nsf_out_buf.
`timescale 1ns / 1ps

module nsf_core
   import nsf_pkg::*;
#(
   parameter int ID_SLOTS = ID_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  req_type                           req,
   input  logic [7:0]                        max_length,
   input  logic [2:0]                        id_count,
   input  logic [ID_SLOTS-1:0][ID_WIDTH-1:0] accept_id,
   output rsp_type                           rsp
);

   typedef enum logic [1:0] {
      PH_DATA,
      PH_HIGH,
      PH_LOW,
      PH_DONE
   } phase_type;

   logic        ready_ff, ready_in;
   logic        started_ff, started_in;
   logic        prop_ff, prop_in;
   logic [7:0]  position_ff, position_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  declared_ff, declared_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] talker_ff, talker_in;
   logic [31:0] sentence_ff, sentence_in;

   logic [2:0]  id_limit;
   logic [31:0] id_word;
   logic        id_hit;
   logic [7:0]  rx;

   assign rx       = req.rx_byte;
   assign id_word  = sentence_ff | {24'd0, rx};
   assign id_limit = (id_count > 3'(ID_SLOTS)) ? 3'(ID_SLOTS) : id_count;

   always_comb begin
      id_hit = 1'b0;
      for (int i = 0; i < ID_SLOTS; i++) begin
         if ((3'(i) < id_limit) && (accept_id[i] == id_word)) id_hit = 1'b1;
      end
   end

   always_comb begin
      ready_in    = ready_ff;
      started_in  = started_ff;
      prop_in     = prop_ff;
      position_in = position_ff;
      xor_in      = xor_ff;
      declared_in = declared_ff;
      phase_in    = phase_ff;
      talker_in   = talker_ff;
      sentence_in = sentence_ff;
      rsp         = '0;
      rsp.status  = ST_BYPASS;

      if (accept) begin
         if (req.op == OP_RELEASE) begin
            ready_in = 1'b0;
         end else if (!ready_ff) begin
            if (rx == CH_START) begin
               started_in       = 1'b1;
               rsp.status       = ST_STARTED;
               xor_in           = 8'd0;
               declared_in      = 8'd0;
               phase_in         = PH_DATA;
               talker_in        = 16'd0;
               sentence_in      = 32'd0;
               prop_in          = 1'b0;
               rsp.byte_index   = 8'd0;
               rsp.byte_out     = rx;
               rsp.store_enable = (max_length != 8'd0);
               position_in      = 8'd1;
            end else if (started_ff) begin
               rsp.status       = ST_IN_PROGRESS;
               rsp.byte_index   = position_ff;
               rsp.byte_out     = rx;
               rsp.store_enable = (position_ff < max_length);
               priority if (rx == CH_LF) begin
                  started_in = 1'b0;
                  ready_in   = 1'b1;
                  rsp.status = ST_READY;
               end else if (rx == CH_STAR) begin
                  phase_in = PH_HIGH;
               end else if (position_ff >= max_length) begin
                  started_in = 1'b0;
                  rsp.status = ST_TOO_BIG;
               end else if (phase_ff == PH_DATA) begin
                  xor_in = xor_ff ^ rx;
                  priority if (position_ff == 8'd1) begin
                     if (rx == CH_PROP) prop_in = 1'b1;
                     else talker_in = {rx, 8'd0};
                  end else if (position_ff == 8'd2) begin
                     if (prop_ff) sentence_in = {rx, 24'd0};
                     else talker_in = {talker_ff[15:8], rx};
                  end else if (position_ff == 8'd3) begin
                     if (prop_ff) sentence_in = sentence_ff | {8'd0, rx, 16'd0};
                     else sentence_in = {8'd0, rx, 16'd0};
                  end else if (position_ff == 8'd4) begin
                     sentence_in = sentence_ff | {16'd0, rx, 8'd0};
                  end else if (position_ff == 8'd5) begin
                     sentence_in = id_word;
                     if (!id_hit) begin
                        started_in = 1'b0;
                        rsp.status = ST_SKIPPING;
                     end
                  end else begin
                  end
               end else if (phase_ff == PH_HIGH) begin
                  declared_in = {hex_value(rx), 4'd0};
                  phase_in    = PH_LOW;
               end else if (phase_ff == PH_LOW) begin
                  declared_in = declared_ff + {4'd0, hex_value(rx)};
                  if (xor_ff != declared_in) begin
                     started_in = 1'b0;
                     rsp.status = ST_CSUM_ERROR;
                  end
                  phase_in = PH_DONE;
               end else begin
               end
               if (position_ff != 8'hFF) position_in = position_ff + 8'd1;
            end
         end
      end

      rsp.talker_code   = talker_in;
      rsp.sentence_code = sentence_in;
      rsp.proprietary   = prop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff    <= 1'b0;
         started_ff  <= 1'b0;
         prop_ff     <= 1'b0;
         position_ff <= 8'd0;
         xor_ff      <= 8'd0;
         declared_ff <= 8'd0;
         phase_ff    <= PH_DATA;
         talker_ff   <= 16'd0;
         sentence_ff <= 32'd0;
      end else begin
         ready_ff    <= ready_in;
         started_ff  <= started_in;
         prop_ff     <= prop_in;
         position_ff <= position_in;
         xor_ff      <= xor_in;
         declared_ff <= declared_in;
         phase_ff    <= phase_in;
         talker_ff   <= talker_in;
         sentence_ff <= sentence_in;
      end
   end

endmodule

// ===== hdl/nsf_out_buf.sv =====
// Two-entry result buffer: output register plus skid stage.
// Depends on nsf_pkg for the result item type.
`timescale 1ns / 1ps

module nsf_out_buf
   import nsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [1:0] CNT_EMPTY = 2'd0;
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_FULL  = 2'd2;

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    skid_ff, skid_in;
   logic       pop;

   assign pop        = (count_ff != CNT_EMPTY) && rsp_ready;
   assign push_ready = (count_ff != CNT_FULL);
   assign rsp_valid  = (count_ff != CNT_EMPTY);
   assign rsp_data   = head_ff;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      skid_in  = skid_ff;
      unique case ({push, pop})
         2'b10: begin
            if (count_ff == CNT_EMPTY) head_in = push_data;
            else skid_in = push_data;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = skid_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == CNT_ONE) begin
               head_in = push_data;
            end else begin
               head_in = skid_ff;
               skid_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_EMPTY;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== hdl/nmea_sentence_framer_top.sv =====
// Top level of the NMEA 0183 sentence framer: registers, core, result buffer.
// Depends on nsf_pkg, nsf_core and nsf_out_buf.
//
//   channel  ports                          direction  item
//   req      req_valid/req_ready/req_data   in         op, rx_byte
//   rsp      rsp_valid/rsp_ready/rsp_data   out        one status result per item
//   csr      csr_wr_en/csr_index/csr_wdata  in         register write, no wait
//
// The core updates the sentence state and its result is written into the result
// buffer on the accepting edge, one item per cycle while req_ready is high.
// The two-entry result buffer sets the stall: req_ready drops only when two
// results wait. Reset is synchronous and clears state, buffer and registers.
`timescale 1ns / 1ps

module nmea_sentence_framer_top
   import nsf_pkg::*;
#(
   parameter int ID_SLOTS = ID_SLOTS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  req_type                               req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rsp_type                               rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [$clog2(CSR_ACCEPT_ID_0+ID_SLOTS)-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]                  csr_wdata
);

   localparam int IDX_W = $clog2(CSR_ACCEPT_ID_0 + ID_SLOTS);

   logic [7:0]                        max_length_ff;
   logic [2:0]                        id_count_ff;
   logic [ID_SLOTS-1:0][ID_WIDTH-1:0] accept_id_ff;
   logic                              accept;
   rsp_type                           core_rsp;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         id_count_ff   <= 3'd0;
         accept_id_ff  <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == IDX_W'(CSR_MAX_LENGTH)) max_length_ff <= csr_wdata[7:0];
         if (csr_index == IDX_W'(CSR_ID_COUNT)) id_count_ff <= csr_wdata[2:0];
         for (int i = 0; i < ID_SLOTS; i++) begin
            if (csr_index == IDX_W'(CSR_ACCEPT_ID_0 + i)) accept_id_ff[i] <= csr_wdata;
         end
      end
   end

   nsf_core #(
      .ID_SLOTS (ID_SLOTS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .max_length (max_length_ff),
      .id_count   (id_count_ff),
      .accept_id  (accept_id_ff),
      .rsp        (core_rsp)
   );

   nsf_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (core_rsp),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item left no result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_bypass_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_BYPASS) |->
         (!rsp_data.store_enable && rsp_data.byte_index == 8'd0))
      else $error("bypass result carries a store");

   a_store_in_buffer: assert property (@(posedge clock) disable iff (reset)
      (accept && core_rsp.store_enable) |-> (core_rsp.byte_index < max_length_ff))
      else $error("store beyond buffer size");
`endif

endmodule
